@@ hdl/lmsbs_pkg.sv @@
// Shared types and constants for the LED matrix serial bit sequencer.
package lmsbs_pkg;

  localparam logic [1:0] COLOUR_RED   = 2'd0;
  localparam logic [1:0] COLOUR_GREEN = 2'd1;
  localparam logic [1:0] COLOUR_BLUE  = 2'd2;

  typedef struct packed {
    logic [7:0] row_bits;
    logic [2:0] column;
    logic [1:0] colour;
  } in_item_t;

  typedef struct packed {
    logic data_bit;
    logic latch_after;
  } out_item_t;

  typedef enum logic [2:0] {
    CNT_HOLD,
    CNT_DEC,
    CNT_LD_COL,
    CNT_LD_PAD,
    CNT_LD_GAP
  } cnt_op_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_ONE,
    SRC_ROW
  } bit_src_t;

  typedef struct packed {
    logic     accept;
    logic     emit;
    bit_src_t src;
    logic     latch;
    logic     shift_row;
    cnt_op_t  cnt_op;
  } cmd_t;

  typedef struct packed {
    logic step;
    logic cnt_zero;
    logic col_zero;
    logic pad_zero;
    logic row_last;
    logic rows_done;
  } status_t;

endpackage

@@ hdl/lmsbs_datapath.sv @@
// Datapath: item registers, phase counter, row shifter and output register.
module lmsbs_datapath #(
  parameter int ROW_COUNT    = 8,
  parameter int COLUMN_COUNT = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  lmsbs_pkg::in_item_t in_data,
  input  logic                out_ready,
  input  lmsbs_pkg::cmd_t     cmd,
  output lmsbs_pkg::status_t  status,
  output logic                out_valid,
  output lmsbs_pkg::out_item_t out_data
);

  localparam int CNT_MAX   = (ROW_COUNT > 8) ? ROW_COUNT : 8;
  localparam int CW        = $clog2(CNT_MAX);
  localparam int RW        = $clog2(ROW_COUNT + 1);
  localparam int COL_LIMIT = COLUMN_COUNT - 1;

  logic [CW-1:0] cnt;
  logic [RW-1:0] row_idx;
  logic [7:0]    rows;
  logic [2:0]    col;
  logic [1:0]    pad;
  logic [2:0]    col_sat;
  logic [1:0]    pad_in;
  logic          data_next;

  always_comb begin
    if ({2'b00, in_data.column} > 5'(COL_LIMIT)) begin
      col_sat = 3'(COL_LIMIT);
    end else begin
      col_sat = in_data.column;
    end
    if (in_data.colour == lmsbs_pkg::COLOUR_RED) begin
      pad_in = 2'd2;
    end else if (in_data.colour == lmsbs_pkg::COLOUR_GREEN) begin
      pad_in = 2'd1;
    end else begin
      pad_in = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rows    <= in_data.row_bits;
      col     <= col_sat;
      pad     <= pad_in;
      row_idx <= '0;
      cnt     <= CW'(ROW_COUNT - 1);
    end else begin
      if (cmd.shift_row) begin
        rows    <= {1'b0, rows[7:1]};
        row_idx <= row_idx + RW'(1);
      end
      case (cmd.cnt_op)
        lmsbs_pkg::CNT_HOLD:   cnt <= cnt;
        lmsbs_pkg::CNT_DEC:    cnt <= cnt - CW'(1);
        lmsbs_pkg::CNT_LD_COL: cnt <= CW'(col) - CW'(1);
        lmsbs_pkg::CNT_LD_PAD: cnt <= CW'(pad) - CW'(1);
        lmsbs_pkg::CNT_LD_GAP: cnt <= CW'(1);
        default:               cnt <= cnt;
      endcase
    end
  end

  always_comb begin
    case (cmd.src)
      lmsbs_pkg::SRC_ZERO: data_next = 1'b0;
      lmsbs_pkg::SRC_ONE:  data_next = 1'b1;
      lmsbs_pkg::SRC_ROW:  data_next = rows[0];
      default:             data_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data.data_bit    <= data_next;
      out_data.latch_after <= cmd.latch;
    end
  end

  always_comb begin
    status.step      = !out_valid || out_ready;
    status.cnt_zero  = (cnt == '0);
    status.col_zero  = (col == '0);
    status.pad_zero  = (pad == '0);
    status.row_last  = (row_idx == RW'(ROW_COUNT - 1));
    status.rows_done = (row_idx == RW'(ROW_COUNT));
  end

`ifndef SYNTHESIS
  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> status.step)
    else $error("emit while output register is blocked");
  a_rows_bounded: assert property (@(posedge clk) disable iff (rst)
    cmd.shift_row |-> !status.rows_done)
    else $error("row shift past last row");
  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("emitted bit not held in output register");
`endif

endmodule

@@ hdl/lmsbs_controller.sv @@
// Controller: state machine that walks the phases of one serial run.
module lmsbs_controller (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  lmsbs_pkg::status_t status,
  output lmsbs_pkg::cmd_t    cmd
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CLEAR  = 7'b0000010,
    ST_SELECT = 7'b0000100,
    ST_COLZ   = 7'b0001000,
    ST_LEAD   = 7'b0010000,
    ST_ROW    = 7'b0100000,
    ST_GAP    = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next    = state;
    cmd.accept    = 1'b0;
    cmd.emit      = 1'b0;
    cmd.src       = lmsbs_pkg::SRC_ZERO;
    cmd.latch     = 1'b0;
    cmd.shift_row = 1'b0;
    cmd.cnt_op    = lmsbs_pkg::CNT_HOLD;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_CLEAR;
        end
      end
      ST_CLEAR: begin
        if (status.step) begin
          cmd.emit = 1'b1;
          if (status.cnt_zero) begin
            state_next = ST_SELECT;
          end else begin
            cmd.cnt_op = lmsbs_pkg::CNT_DEC;
          end
        end
      end
      ST_SELECT: begin
        if (status.step) begin
          cmd.emit = 1'b1;
          cmd.src  = lmsbs_pkg::SRC_ONE;
          if (!status.col_zero) begin
            cmd.cnt_op = lmsbs_pkg::CNT_LD_COL;
            state_next = ST_COLZ;
          end else if (!status.pad_zero) begin
            cmd.cnt_op = lmsbs_pkg::CNT_LD_PAD;
            state_next = ST_LEAD;
          end else begin
            state_next = ST_ROW;
          end
        end
      end
      ST_COLZ: begin
        if (status.step) begin
          cmd.emit = 1'b1;
          if (!status.cnt_zero) begin
            cmd.cnt_op = lmsbs_pkg::CNT_DEC;
          end else if (!status.pad_zero) begin
            cmd.cnt_op = lmsbs_pkg::CNT_LD_PAD;
            state_next = ST_LEAD;
          end else begin
            state_next = ST_ROW;
          end
        end
      end
      ST_LEAD: begin
        if (status.step) begin
          cmd.emit = 1'b1;
          if (status.cnt_zero) begin
            state_next = ST_ROW;
          end else begin
            cmd.cnt_op = lmsbs_pkg::CNT_DEC;
          end
        end
      end
      ST_ROW: begin
        if (status.step) begin
          cmd.emit      = 1'b1;
          cmd.src       = lmsbs_pkg::SRC_ROW;
          cmd.shift_row = 1'b1;
          if (!status.row_last) begin
            cmd.cnt_op = lmsbs_pkg::CNT_LD_GAP;
            state_next = ST_GAP;
          end else if (!status.pad_zero) begin
            cmd.cnt_op = lmsbs_pkg::CNT_LD_PAD;
            state_next = ST_GAP;
          end else begin
            cmd.latch  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      ST_GAP: begin
        if (status.step) begin
          cmd.emit = 1'b1;
          if (!status.cnt_zero) begin
            cmd.cnt_op = lmsbs_pkg::CNT_DEC;
          end else if (status.rows_done) begin
            cmd.latch  = 1'b1;
            state_next = ST_IDLE;
          end else begin
            state_next = ST_ROW;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !cmd.emit)
    else $error("bit emitted while idle");
  a_latch_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |=> (state == ST_IDLE))
    else $error("latch bit did not end the run");
  a_latch_emits: assert property (@(posedge clk) disable iff (rst)
    cmd.latch |-> cmd.emit)
    else $error("latch flag without emitted bit");
`endif

endmodule

@@ hdl/led_matrix_serial_bit_sequencer.sv @@
// Top level of the LED matrix serial bit sequencer.
//
// Input channel (in_valid/in_ready/in_data): one transfer per column and
// colour plane, carrying eight row bits, the column index and the colour.
// Output channel (out_valid/out_ready/out_data): one transfer per serial
// bit, with latch_after set on the last bit of each run.
// A run is ROW_COUNT zeros, a one, column zeros, (2 - colour) zeros, then
// the row bits LSB first with two zeros between them and (2 - colour)
// zeros after the last. Colour three acts as blue; a column past the
// matrix saturates to COLUMN_COUNT - 1.
// An input transfer moves the state machine to its clear state; the first
// bit is registered into the single output register and raises out_valid.
// Bits are emitted one per cycle while that register is free; a run is at
// most 42 bits with default parameters. in_ready is high only between
// runs; the next item is taken while the final bit waits in the output
// register. When the receiver stalls, the sequencer holds its place until
// the output register frees. Reset returns to idle and drops out_valid.
module led_matrix_serial_bit_sequencer #(
  parameter int ROW_COUNT    = 8,
  parameter int COLUMN_COUNT = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lmsbs_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lmsbs_pkg::out_item_t out_data
);

  lmsbs_pkg::cmd_t    cmd;
  lmsbs_pkg::status_t status;

  lmsbs_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lmsbs_datapath #(
    .ROW_COUNT    (ROW_COUNT),
    .COLUMN_COUNT (COLUMN_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
